// ===== design/stli_pkg.sv =====
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants of the interpolation table
// Item layout between the front and back, operation codes, table limits.
// ----------------------------------------------------------------------------
package stli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int INDEX_WIDTH = 8;
   localparam int COUNT_WIDTH = 9;
   localparam int DATA_WIDTH  = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STATUS_INSIDE = 2'd0;
   localparam logic [1:0] STATUS_BELOW  = 2'd1;
   localparam logic [1:0] STATUS_ABOVE  = 2'd2;

   localparam logic [COUNT_WIDTH-1:0] INDEX_NONE = '1;

   typedef struct packed {
      logic                    is_query;
      logic [INDEX_WIDTH-1:0]  index;
      logic [DATA_WIDTH-1:0]   x;
      logic [DATA_WIDTH-1:0]   y;
      logic [DATA_WIDTH-1:0]   v;
   } item_type;

endpackage

// ===== design/stli_front.sv =====
// ----------------------------------------------------------------------------
// stli_front: request intake and item queue
// Accepts request transactions, tags writes and queries, holds two items.
// ----------------------------------------------------------------------------
module stli_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [103:0]        req_tdata,
   input  logic                req_tuser,
   output logic                item_valid,
   output stli_pkg::item_type  item,
   input  logic                item_pop
);

   stli_pkg::item_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   stli_pkg::item_type new_item;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_query = (req_tuser == stli_pkg::OP_QUERY);
      new_item.index    = req_tdata[7:0];
      new_item.x        = req_tdata[39:8];
      new_item.y        = req_tdata[71:40];
      new_item.v        = req_tdata[103:72];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/stli_back.sv =====
// ----------------------------------------------------------------------------
// stli_back: table store, binary search and interpolation sequencer
// Holds the point memories, searches them one probe at a time, then runs
// one multiply and a bit-serial divide for the interpolated value.
// ----------------------------------------------------------------------------
module stli_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [8:0]          entries_used,
   input  logic                item_valid,
   input  stli_pkg::item_type  item,
   output logic                item_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_W0, ST_C0, ST_WN, ST_CN, ST_WM, ST_CM,
      ST_PREP, ST_MUL, ST_DIV, ST_FIN, ST_DONE
   } state_type;

   state_type state_ff;

   logic [31:0] mem_x [stli_pkg::TABLE_DEPTH];
   logic [31:0] mem_y [stli_pkg::TABLE_DEPTH];
   logic [7:0]  rd_addr_ff;
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic        mem_we;

   logic signed [31:0] v_ff, xl_ff, yl_ff, xr_ff, yr_ff;
   logic [7:0]  l_ff, r_ff, last_ff;
   logic [31:0] mv_ff, my_ff, mx_ff;
   logic        neg_ff;
   logic [63:0] prod_ff;
   logic [31:0] rem_ff, quo_ff;
   logic [5:0]  cnt_ff;

   logic [31:0] res_val_ff;
   logic [8:0]  res_l_ff, res_r_ff;
   logic [1:0]  res_st_ff;
   logic [31:0] out_val_ff;
   logic [8:0]  out_l_ff, out_r_ff;
   logic [1:0]  out_st_ff;
   logic        out_valid_ff;

   logic [7:0]  last_idx;
   logic [8:0]  sum_lr;
   logic [7:0]  mid;
   logic [7:0]  nl, nr;
   logic [8:0]  nsum;
   logic        more;
   logic signed [32:0] dv, dy, dx;
   logic [32:0] rem_sh, rem_diff;
   logic        ge;
   logic [31:0] q_signed;

   // clamp the register: zero acts as one entry, counts past the depth as the full table
   always_comb begin
      if (entries_used == 9'd0) begin
         last_idx = 8'd0;
      end else if (entries_used > 9'(stli_pkg::TABLE_DEPTH)) begin
         last_idx = 8'(stli_pkg::TABLE_DEPTH - 1);
      end else begin
         last_idx = 8'(entries_used - 9'd1);
      end
   end

   assign mem_we   = (state_ff == ST_IDLE) && item_valid && !item.is_query;
   assign item_pop = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[item.index] <= item.x;
         mem_y[item.index] <= item.y;
      end
      rd_x_ff <= mem_x[rd_addr_ff];
      rd_y_ff <= mem_y[rd_addr_ff];
   end

   always_comb begin
      sum_lr = {1'b0, l_ff} + {1'b0, r_ff};
      mid    = sum_lr[8:1];
      if (v_ff < rd_x_ff) begin
         nl = l_ff;
         nr = mid;
      end else begin
         nl = mid;
         nr = r_ff;
      end
      nsum = {1'b0, nl} + {1'b0, nr};
      more = ({1'b0, nr} > ({1'b0, nl} + 9'd1));
      dv = 33'(v_ff) - 33'(xl_ff);
      dy = 33'(yr_ff) - 33'(yl_ff);
      dx = 33'(xr_ff) - 33'(xl_ff);
      rem_sh   = {rem_ff, prod_ff[63]};
      rem_diff = rem_sh - {1'b0, mx_ff};
      ge       = (rem_sh >= {1'b0, mx_ff});
      q_signed = neg_ff ? (32'd0 - quo_ff) : quo_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_r_ff, out_l_ff, out_val_ff};
   assign rsp_tuser  = out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && (state_ff != ST_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_valid && item.is_query) begin
                  v_ff       <= item.v;
                  last_ff    <= last_idx;
                  rd_addr_ff <= 8'd0;
                  state_ff   <= ST_W0;
               end
            end
            ST_W0: state_ff <= ST_C0;
            ST_C0: begin
               xl_ff <= rd_x_ff;
               yl_ff <= rd_y_ff;
               l_ff  <= 8'd0;
               if (v_ff < rd_x_ff) begin
                  res_val_ff <= 32'd0;
                  res_l_ff   <= stli_pkg::INDEX_NONE;
                  res_r_ff   <= 9'd0;
                  res_st_ff  <= stli_pkg::STATUS_BELOW;
                  state_ff   <= ST_DONE;
               end else begin
                  rd_addr_ff <= last_ff;
                  state_ff   <= ST_WN;
               end
            end
            ST_WN: state_ff <= ST_CN;
            ST_CN: begin
               xr_ff     <= rd_x_ff;
               yr_ff     <= rd_y_ff;
               r_ff      <= last_ff;
               res_st_ff <= (v_ff > rd_x_ff) ? stli_pkg::STATUS_ABOVE : stli_pkg::STATUS_INSIDE;
               if (v_ff > rd_x_ff) begin
                  res_val_ff <= 32'd0;
                  res_l_ff   <= {1'b0, last_ff};
                  res_r_ff   <= stli_pkg::INDEX_NONE;
                  state_ff   <= ST_DONE;
               end else if (v_ff == xl_ff) begin
                  res_val_ff <= yl_ff;
                  res_l_ff   <= 9'd0;
                  res_r_ff   <= 9'd0;
                  state_ff   <= ST_DONE;
               end else if (v_ff == rd_x_ff) begin
                  res_val_ff <= rd_y_ff;
                  res_l_ff   <= {1'b0, last_ff};
                  res_r_ff   <= {1'b0, last_ff};
                  state_ff   <= ST_DONE;
               end else if (last_ff > 8'd1) begin
                  rd_addr_ff <= last_ff >> 1;
                  state_ff   <= ST_WM;
               end else begin
                  state_ff <= ST_PREP;
               end
            end
            ST_WM: state_ff <= ST_CM;
            ST_CM: begin
               if (v_ff == rd_x_ff) begin
                  res_val_ff <= rd_y_ff;
                  res_l_ff   <= {1'b0, mid};
                  res_r_ff   <= {1'b0, mid};
                  state_ff   <= ST_DONE;
               end else begin
                  if (v_ff < rd_x_ff) begin
                     xr_ff <= rd_x_ff;
                     yr_ff <= rd_y_ff;
                  end else begin
                     xl_ff <= rd_x_ff;
                     yl_ff <= rd_y_ff;
                  end
                  l_ff <= nl;
                  r_ff <= nr;
                  if (more) begin
                     rd_addr_ff <= nsum[8:1];
                     state_ff   <= ST_WM;
                  end else begin
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               res_l_ff <= {1'b0, l_ff};
               res_r_ff <= {1'b0, r_ff};
               mv_ff    <= dv[32] ? 32'(-dv) : dv[31:0];
               my_ff    <= dy[32] ? 32'(-dy) : dy[31:0];
               mx_ff    <= dx[32] ? 32'(-dx) : dx[31:0];
               neg_ff   <= dv[32] ^ dy[32] ^ dx[32];
               if (dx == 33'sd0) begin
                  res_val_ff <= yl_ff;
                  state_ff   <= ST_DONE;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= 64'(mv_ff) * 64'(my_ff);
               rem_ff   <= 32'd0;
               quo_ff   <= 32'd0;
               cnt_ff   <= 6'd0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // restoring divide, one quotient bit per cycle
               rem_ff  <= ge ? rem_diff[31:0] : rem_sh[31:0];
               quo_ff  <= {quo_ff[30:0], ge};
               prod_ff <= {prod_ff[62:0], 1'b0};
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               res_val_ff <= yl_ff + q_signed;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_val_ff   <= res_val_ff;
                  out_l_ff     <= res_l_ff;
                  out_r_ff     <= res_r_ff;
                  out_st_ff    <= res_st_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CM) |-> (l_ff < r_ff))
      else $error("search bracket collapsed");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (mx_ff != 32'd0))
      else $error("divide by zero");

   a_below_marks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_st_ff == stli_pkg::STATUS_BELOW) |->
      (out_l_ff == stli_pkg::INDEX_NONE && out_val_ff == 32'd0))
      else $error("below-table result malformed");

endmodule

// ===== design/sorted_table_linear_interpolator.sv =====
// a write item is stored while the sequencer is idle; a query item reads the
// first and last entries, then searches with up to 8 probes, and when
// interpolating runs one multiply and a bit-serial divide before the
// registered response
// throughput: one item at a time in the sequencer; a two-entry queue takes
// requests while it works. reset clears control state, entries_used to 1
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: piecewise linear lookup table
// Stores sample points and returns interpolated values for query transactions.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // entry_index, entry_x, entry_y, query_value
   input  logic         req_tuser,  // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,  // interp_value, left_index, right_index
   output logic [1:0]   rsp_tuser,  // range_status
   input  logic         csr_wen,
   input  logic [8:0]   csr_wdata
);

   logic [8:0]          entries_used_ff;
   logic                item_valid;
   logic                item_pop;
   stli_pkg::item_type  item;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_used_ff <= 9'd1;
      end else if (csr_wen) begin
         entries_used_ff <= csr_wdata;
      end
   end

   stli_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   stli_back u_back (
      .clock        (clock),
      .reset        (reset),
      .entries_used (entries_used_ff),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ===== tb/stli_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stli_checker: response checker of the interpolation table
// Tracks table writes and the point count, predicts every query response and
// compares it field by field with the returned transaction, in order.
// ----------------------------------------------------------------------------
module stli_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [55:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic [8:0]   csr_wdata,
   output int           errors,
   output int           pending
);

   typedef struct packed {
      logic [31:0] value;
      logic [8:0]  left;
      logic [8:0]  right;
      logic [1:0]  status;
   } lookup_result_type;

   logic signed [31:0] abscissa [stli_pkg::TABLE_DEPTH];
   logic signed [31:0] ordinate [stli_pkg::TABLE_DEPTH];
   logic [8:0]         points_cfg;
   lookup_result_type  lookup_queue[$];

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      errors++;
   endtask

   function automatic logic [31:0] blend(input logic signed [31:0] v, input int l, input int r);
      longint dv, dy, dx;
      bit [63:0] mv, my, mx, q;
      bit neg;
      dv = longint'(v) - longint'(abscissa[l]);
      dy = longint'(ordinate[r]) - longint'(ordinate[l]);
      dx = longint'(abscissa[r]) - longint'(abscissa[l]);
      if (dx == 0) return ordinate[l];
      neg = (dv < 0) ^ (dy < 0) ^ (dx < 0);
      mv = (dv < 0) ? -dv : dv;
      my = (dy < 0) ? -dy : dy;
      mx = (dx < 0) ? -dx : dx;
      q = (mv * my) / mx;
      if (neg) q = -q;
      return ordinate[l] + q[31:0];
   endfunction

   function automatic lookup_result_type predict_lookup(input logic signed [31:0] v);
      lookup_result_type res;
      int n, l, r, m;
      n = points_cfg;
      if (n < 1) n = 1;
      if (n > stli_pkg::TABLE_DEPTH) n = stli_pkg::TABLE_DEPTH;
      res = '0;
      if (v < abscissa[0]) begin
         l = -1; r = 0; res.status = stli_pkg::STATUS_BELOW;
      end else if (v > abscissa[n-1]) begin
         l = n - 1; r = -1; res.status = stli_pkg::STATUS_ABOVE;
      end else begin
         l = 0;
         r = n - 1;
         res.status = stli_pkg::STATUS_INSIDE;
         if (v == abscissa[l]) r = l;
         else if (v == abscissa[r]) l = r;
         else begin
            while (r - l > 1) begin
               m = (l + r) / 2;
               if (v == abscissa[m]) begin
                  l = m;
                  r = m;
               end else if (v < abscissa[m]) r = m;
               else l = m;
            end
         end
         res.value = (l == r) ? ordinate[l] : blend(v, l, r);
      end
      res.left  = l[8:0];
      res.right = r[8:0];
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         points_cfg = 9'd1;
         lookup_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lookup_queue.size() == 0) begin
               $display("%0t: response transaction with none expected", $realtime);
               errors++;
            end else begin
               want = lookup_queue.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report("interp_value", rsp_tdata[31:0], want.value);
               if (rsp_tdata[40:32] !== want.left)
                  report("left_index", 32'(rsp_tdata[40:32]), 32'(want.left));
               if (rsp_tdata[49:41] !== want.right)
                  report("right_index", 32'(rsp_tdata[49:41]), 32'(want.right));
               if (rsp_tuser !== want.status)
                  report("range_status", 32'(rsp_tuser), 32'(want.status));
            end
         end
         if (csr_wen) points_cfg = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == stli_pkg::OP_WRITE) begin
               abscissa[req_tdata[7:0]] = req_tdata[39:8];
               ordinate[req_tdata[7:0]] = req_tdata[71:40];
            end else begin
               lookup_queue.push_back(predict_lookup(req_tdata[103:72]));
            end
         end
      end
      pending <= lookup_queue.size();
   end

endmodule

// ===== tb/sorted_table_linear_interpolator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_test: stimulus for the interpolation table
// Loads sorted tables, runs directed and random write and query transactions
// under several point counts and backpressure patterns, and gives the verdict.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_test;

   localparam int STALL_LIMIT    = 20000;
   localparam int RX_HOLD_CYCLES = 600;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;   // entry_index, entry_x, entry_y, query_value
   logic         req_tuser;   // operation
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;   // interp_value, left_index, right_index
   logic [1:0]   rsp_tuser;   // range_status
   logic         csr_wen;
   logic [8:0]   csr_wdata;
   int           errors;
   int           pending;

   int tx_idle_pct;
   int rx_idle_pct;
   int rx_hold;
   logic hold_toggle;
   logic hold_seen;
   int quiet_cycles;
   int points;
   logic signed [31:0] table_x [stli_pkg::TABLE_DEPTH];

   sorted_table_linear_interpolator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   stli_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when the toggle flips
   always @(posedge clock) begin
      hold_seen <= hold_toggle;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold    <= 0;
      end else if (hold_toggle != hold_seen) begin
         rsp_tready <= 1'b0;
         rx_hold    <= RX_HOLD_CYCLES;
      end else if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= rx_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** sorted_table_linear_interpolator: FAILED **");
         $finish;
      end
   end

   task automatic send(input logic op, input logic [7:0] idx, input logic [31:0] x,
                       input logic [31:0] y, input logic [31:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, y, x, idx};
      do @(posedge clock); while (!req_tready);
      if (op == stli_pkg::OP_WRITE) table_x[idx] = x;
   endtask

   task automatic write_point(input logic [7:0] idx, input logic [31:0] x, input logic [31:0] y);
      send(stli_pkg::OP_WRITE, idx, x, y, $urandom);
   endtask

   task automatic query(input logic [31:0] v);
      send(stli_pkg::OP_QUERY, 8'($urandom), $urandom, $urandom, v);
   endtask

   // waits out every response, then lets the queue settle
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_points(input logic [8:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      points = (value < 1) ? 1 : (value > stli_pkg::TABLE_DEPTH) ? stli_pkg::TABLE_DEPTH : value;
   endtask

   task automatic load_sorted_table;
      logic signed [31:0] x;
      x = 32'sh8000_0000 + $urandom_range(32'h3fff_ffff);
      for (int i = 0; i < stli_pkg::TABLE_DEPTH; i++) begin
         write_point(8'(i), x, $urandom);
         x = x + $urandom_range(1, 32'h0040_0000);
      end
   endtask

   function automatic logic [31:0] pick_query;
      int k;
      logic signed [31:0] a;
      k = $urandom_range(points - 1);
      a = table_x[k];
      case ($urandom_range(9))
         0, 1: return a;
         2:    return a + 1;
         3:    return a - 1;
         4:    return 32'h8000_0000;
         5:    return 32'h7fff_ffff;
         6:    return $urandom;
         default: begin
            if (k + 1 < points)
               return a + ((table_x[k+1] - a) >>> 1) + $urandom_range(3);
            return a + $urandom_range(255);
         end
      endcase
   endfunction

   initial begin
      logic [8:0] phase_points [9];
      int idx;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = stli_pkg::OP_WRITE;
      csr_wen = 1'b0;
      csr_wdata = '0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_toggle = 1'b0;
      points = 1;
      phase_points = '{9'd256, 9'd2, 9'd511, 9'd37, 9'd1, 9'd0, 9'd128, 9'd3, 9'd300};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a single point at reset count, then the full table
      load_sorted_table();
      query(table_x[0] - 1);
      query(table_x[0]);
      query(table_x[0] + 1);
      drain();
      set_points(9'd511);
      query(32'h8000_0000);
      query(32'h7fff_ffff);
      query(table_x[255]);
      query(table_x[128]);
      query(table_x[127] + 1);
      query(table_x[254] + 1);
      drain();
      set_points(9'd0);
      query(table_x[0]);
      query(32'h7fff_ffff);
      drain();
      // extreme coordinates on a two point table
      set_points(9'd2);
      write_point(8'd0, 32'h8000_0000, 32'h7fff_ffff);
      write_point(8'd1, 32'h7fff_ffff, 32'h8000_0000);
      query(32'h0000_0000);
      query(32'hffff_ffff);
      query(32'h8000_0000);
      query(32'h7fff_ffff);
      query(32'h8000_0001);
      write_point(8'd255, 32'h7fff_ffff, 32'h7fff_ffff);
      drain();
      load_sorted_table();
      drain();

      for (int p = 0; p < 9; p++) begin
         tx_idle_pct = (p < 3) ? 16 : (p < 6) ? 69 : 0;
         rx_idle_pct = (p < 3) ? 69 : (p < 6) ? 16 : 0;
         set_points((p == 7) ? 9'($urandom_range(2, 256)) : phase_points[p]);
         for (int i = 0; i < 70; i++) begin
            if (p == 1 && i == 5) hold_toggle = ~hold_toggle;
            idx = $urandom_range(stli_pkg::TABLE_DEPTH - 1);
            case ($urandom_range(9))
               0, 1: write_point(8'(idx), table_x[idx], $urandom);
               2:    write_point(8'(idx), $urandom, $urandom);
               default: query(pick_query());
            endcase
         end
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("** sorted_table_linear_interpolator: PASSED **");
      else
         $display("** sorted_table_linear_interpolator: FAILED **");
      $finish;
   end

endmodule

// ===== sorted_table_linear_interpolator.f =====
design/stli_pkg.sv
design/stli_front.sv
design/stli_back.sv
design/sorted_table_linear_interpolator.sv
tb/stli_checker.sv
tb/sorted_table_linear_interpolator_test.sv
